// File: rtl/sorted_table_binary_search_macros.svh
// Assertion macros shared by the sorted table search RTL.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clock outside reset.
`define STBS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising edge of clock outside reset.
`define STBS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/stbs_pkg.sv
// Shared types, widths and codes for the sorted table binary search block.
package stbs_pkg;

   // Field widths.
   localparam int SLOT_W = 3;
   localparam int KEY_W = 32;
   localparam int PAY_W = 48;
   localparam int USED_W = 4;
   localparam int REC_W = KEY_W + PAY_W;

   // Stream data widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = ((SLOT_W + KEY_W + PAY_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((SLOT_W + PAY_W + 7) / 8) * 8;

   // Default table depth and reset value of the used-entries register.
   localparam int TABLE_DEPTH_DEF = 8;
   localparam logic [USED_W-1:0] USED_RESET = 4'd8;

   // Operation codes carried in the request tuser.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_PROBE
   } stbs_state_type;

   // One request beat as seen by the search engine.
   typedef struct packed {
      logic op;
      logic [SLOT_W-1:0] slot;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } stbs_cmd_type;

   // One search result.
   typedef struct packed {
      logic found;
      logic [SLOT_W-1:0] slot;
      logic [PAY_W-1:0] payload;
   } stbs_res_type;

endpackage

// File: rtl/stbs_engine.sv
// Record memory and binary search sequencer, one memory probe per cycle.
module stbs_engine #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   output logic cmd_ready,
   input  stbs_pkg::stbs_cmd_type cmd,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0] used_n,
   input  logic out_free,
   output logic res_valid,
   output stbs_pkg::stbs_res_type res
);

`include "sorted_table_binary_search_macros.svh"

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int S_W = CNT_W + 1;
   localparam logic signed [S_W-1:0] ONE_S = 1;

   stbs_pkg::stbs_state_type state_ff, state_in;

   logic signed [S_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic signed [stbs_pkg::KEY_W-1:0] sought_ff, sought_in;

   logic [stbs_pkg::REC_W-1:0] mem [TABLE_DEPTH];
   logic [stbs_pkg::REC_W-1:0] rd_data_ff;

   logic wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr;
   logic accept_search;
   logic signed [stbs_pkg::KEY_W-1:0] rd_key;
   logic [stbs_pkg::PAY_W-1:0] rd_pay;
   logic signed [S_W-1:0] mid_s, lo_nx, hi_nx, hi_init;
   logic signed [S_W:0] sum_nx;
   logic probe_ok, key_eq, key_lt, more;
   logic [CNT_W-1:0] mid0;

   // Record memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {cmd.payload, cmd.key};
      end
      if (rd_en) begin
         rd_data_ff <= mem[mid_in];
      end
   end

   assign rd_key = rd_data_ff[stbs_pkg::KEY_W-1:0];
   assign rd_pay = rd_data_ff[stbs_pkg::REC_W-1:stbs_pkg::KEY_W];

   // Probe evaluation: compare and narrow the interval.
   always_comb begin
      mid_s = $signed({{(S_W-IDX_W){1'b0}}, mid_ff});
      probe_ok = (lo_ff <= hi_ff);
      key_eq = (sought_ff == rd_key);
      key_lt = (sought_ff < rd_key);
      lo_nx = lo_ff;
      hi_nx = hi_ff;
      if (key_lt) begin
         hi_nx = mid_s - ONE_S;
      end else begin
         lo_nx = mid_s + ONE_S;
      end
      sum_nx = {lo_nx[S_W-1], lo_nx} + {hi_nx[S_W-1], hi_nx};
      more = probe_ok && !key_eq && (lo_nx <= hi_nx);
   end

   // Initial interval of a new search; an empty table gives lo above hi.
   always_comb begin
      hi_init = $signed({1'b0, used_n} - {{CNT_W{1'b0}}, 1'b1});
      mid0 = (used_n == '0) ? '0 : ((used_n - {{(CNT_W-1){1'b0}}, 1'b1}) >> 1);
   end

   assign accept_search = (state_ff == stbs_pkg::ST_IDLE) && cmd_valid
                          && (cmd.op == stbs_pkg::OP_SEARCH);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stbs_pkg::ST_IDLE: begin
            if (accept_search) begin
               state_in = stbs_pkg::ST_PROBE;
            end
         end
         stbs_pkg::ST_PROBE: begin
            if (!more && out_free) begin
               state_in = stbs_pkg::ST_IDLE;
            end
         end
         default: state_in = stbs_pkg::ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      cmd_ready = 1'b0;
      res_valid = 1'b0;
      rd_en = 1'b0;
      wr_en = 1'b0;
      unique case (state_ff)
         stbs_pkg::ST_IDLE: begin
            cmd_ready = 1'b1;
            rd_en = accept_search;
            wr_en = cmd_valid && (cmd.op == stbs_pkg::OP_WRITE)
                    && (32'(cmd.slot) < TABLE_DEPTH);
         end
         stbs_pkg::ST_PROBE: begin
            rd_en = more;
            res_valid = !more && out_free;
         end
         default: begin
            cmd_ready = 1'b0;
         end
      endcase
   end

   assign wr_addr = IDX_W'(cmd.slot);

   // Interval registers load on a new search or a further probe.
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      sought_in = sought_ff;
      if (accept_search) begin
         lo_in = '0;
         hi_in = hi_init;
         mid_in = IDX_W'(mid0);
         sought_in = cmd.key;
      end else if ((state_ff == stbs_pkg::ST_PROBE) && more) begin
         lo_in = lo_nx;
         hi_in = hi_nx;
         mid_in = sum_nx[IDX_W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      sought_ff <= sought_in;
   end

   // Result: the probed slot on a hit, all zeros on a miss.
   always_comb begin
      res.found = probe_ok && key_eq;
      res.slot = res.found ? stbs_pkg::SLOT_W'(mid_ff) : '0;
      res.payload = res.found ? rd_pay : '0;
   end

   `STBS_ASSERT_IMP(a_res_fits, res_valid, out_free, "result issued while output register is busy")
   `STBS_ASSERT_IMP(a_mid_in_range, (state_ff == stbs_pkg::ST_PROBE) && probe_ok, (mid_s >= lo_ff) && (mid_s <= hi_ff), "probe index outside search interval")
   `STBS_ASSERT_IMP(a_rd_wr_apart, rd_en, !wr_en, "memory read and write in the same cycle")

endmodule

// File: rtl/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
//
// Usage: the req_ channel carries one beat per operation. A write beat
// (tuser = 0) stores key and payload at the given slot and gives no result;
// slots at or beyond the table depth are ignored. A search beat (tuser = 1)
// runs a binary search over slots 0 .. used_entries-1, which must be sorted
// ascending by signed key and written beforehand, and gives one rsp_ beat:
// tuser is the found flag, tdata the slot and payload (zeros on a miss).
// used_entries is set through csr_we / csr_wdata; the user must set it only
// while the block is idle, as the block itself does not enforce this.
// Values above the table depth search the whole table. A write beat leaves
// the engine idle; a search holds req_tready low until its result issues,
// and reads the record memory's single port once per probe. The result
// enters the output register at the edge that ends the last probe.
// The output register lets a new beat be accepted while a result waits; if
// the receiver stalls, a finished search holds until the register frees.
// Reset is synchronous: it clears the control state and sets used_entries
// to 8; table contents are undefined until written.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [2:0] entry_slot, [34:3] entry_key, [82:35] entry_payload, rest zero
   input  logic [stbs_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] opcode
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [2:0] match_slot, [50:3] match_payload, rest zero
   output logic [stbs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] found
   output logic rsp_tuser,
   input  logic csr_we,
   input  logic [stbs_pkg::USED_W-1:0] csr_wdata
);

`include "sorted_table_binary_search_macros.svh"

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int SLOT_LO = 0;
   localparam int KEY_LO = SLOT_LO + stbs_pkg::SLOT_W;
   localparam int PAY_LO = KEY_LO + stbs_pkg::KEY_W;

   logic [stbs_pkg::USED_W-1:0] used_entries_ff;
   logic [CNT_W-1:0] used_n;
   stbs_pkg::stbs_cmd_type cmd;
   stbs_pkg::stbs_res_type res, rsp_ff, rsp_in;
   logic res_valid, out_free;
   logic rsp_valid_ff, rsp_valid_in;

   // Used-entries register.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_entries_ff <= stbs_pkg::USED_RESET;
      end else if (csr_we) begin
         used_entries_ff <= csr_wdata;
      end
   end

   // Search range saturates at the table depth.
   always_comb begin
      if (32'(used_entries_ff) > TABLE_DEPTH) begin
         used_n = CNT_W'(TABLE_DEPTH);
      end else begin
         used_n = CNT_W'(used_entries_ff);
      end
   end

   // Unpack the request beat.
   always_comb begin
      cmd.op = req_tuser;
      cmd.slot = req_tdata[KEY_LO-1:SLOT_LO];
      cmd.key = req_tdata[PAY_LO-1:KEY_LO];
      cmd.payload = req_tdata[PAY_LO+stbs_pkg::PAY_W-1:PAY_LO];
   end

   stbs_engine #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .cmd_valid(req_tvalid),
      .cmd_ready(req_tready),
      .cmd(cmd),
      .used_n(used_n),
      .out_free(out_free),
      .res_valid(res_valid),
      .res(res)
   );

   // Output register.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_in = res;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_ff.found;
   assign rsp_tdata = {{(stbs_pkg::RSP_DATA_W - stbs_pkg::SLOT_W - stbs_pkg::PAY_W){1'b0}},
                       rsp_ff.payload, rsp_ff.slot};

   `STBS_ASSERT_NXT(a_busy_after_search, req_tvalid && req_tready && (req_tuser == stbs_pkg::OP_SEARCH), !req_tready, "new beat accepted while a search runs")

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the sorted table binary search block.
`timescale 1ns / 1ps

module testbench;

   localparam int DEPTH = stbs_pkg::TABLE_DEPTH_DEF;
   localparam int REQ_PAD = stbs_pkg::REQ_DATA_W - stbs_pkg::SLOT_W - stbs_pkg::KEY_W
                            - stbs_pkg::PAY_W;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD = 300;
   localparam int PHASE_BEATS = 85;
   localparam int KEY_MIN = 32'sh8000_0000;
   localparam int KEY_MAX = 32'sh7fff_ffff;

   // Clock, reset and every block input start at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [stbs_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [stbs_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic [stbs_pkg::USED_W-1:0] csr_wdata = '0;

   // Beats waiting to be sent, and search answers waiting to come back.
   stbs_pkg::stbs_cmd_type req_backlog[$];
   stbs_pkg::stbs_res_type lookup_results[$];
   stbs_pkg::stbs_cmd_type req_beat;

   // Predicted contents of the block.
   logic signed [stbs_pkg::KEY_W-1:0] key_table [DEPTH];
   logic [stbs_pkg::PAY_W-1:0] payload_table [DEPTH];
   logic [stbs_pkg::USED_W-1:0] used_cfg = stbs_pkg::USED_RESET;

   // Keys as the stimulus generator last queued them, for picking search keys.
   int gen_keys [DEPTH];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;
   int fail_count = 0;
   int write_beats = 0;
   int search_beats = 0;
   int hit_beats = 0;
   int phase_queued = 0;
   int settings_used = 0;

   sorted_table_binary_search i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one accepted beat to the predicted table, or work out the search answer.
   task automatic predict_beat(input stbs_pkg::stbs_cmd_type c);
      stbs_pkg::stbs_res_type ans;
      int n;
      int lo;
      int hi;
      int mid;
      ans = '0;
      if (c.op == stbs_pkg::OP_WRITE) begin
         if (int'(c.slot) < DEPTH) begin
            key_table[c.slot] = c.key;
            payload_table[c.slot] = c.payload;
         end
      end else begin
         n = int'(used_cfg);
         if (n > DEPTH) begin
            n = DEPTH;
         end
         lo = 0;
         hi = n - 1;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (c.key == key_table[mid]) begin
               ans.found = 1'b1;
               ans.slot = stbs_pkg::SLOT_W'(mid);
               ans.payload = payload_table[mid];
               break;
            end
            if (c.key < key_table[mid]) begin
               hi = mid - 1;
            end else begin
               lo = mid + 1;
            end
         end
         lookup_results.push_back(ans);
      end
   endtask

   // Request driver: predicts each beat as it is accepted, then offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_beat(req_beat);
            if (req_beat.op == stbs_pkg::OP_WRITE) begin
               write_beats <= write_beats + 1;
            end else begin
               search_beats <= search_beats + 1;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_beat <= req_backlog[0];
               req_tdata <= {{REQ_PAD{1'b0}}, req_backlog[0].payload,
                             req_backlog[0].key, req_backlog[0].slot};
               req_tuser <= req_backlog[0].op;
               req_tvalid <= 1'b1;
               void'(req_backlog.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each result beat against the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      stbs_pkg::stbs_res_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (lookup_results.size() == 0) begin
               $error("result beat arrived with no search outstanding");
               fail_count++;
            end else begin
               want = lookup_results.pop_front();
               if (want.found) begin
                  hit_beats <= hit_beats + 1;
               end
               if (rsp_tuser !== want.found) begin
                  $error("found mismatch: expected %0d, actual %0d", want.found, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[stbs_pkg::SLOT_W-1:0] !== want.slot) begin
                  $error("match_slot mismatch: expected %0d, actual %0d",
                         want.slot, rsp_tdata[stbs_pkg::SLOT_W-1:0]);
                  fail_count++;
               end
               if (rsp_tdata[stbs_pkg::SLOT_W +: stbs_pkg::PAY_W] !== want.payload) begin
                  $error("match_payload mismatch: expected %h, actual %h",
                         want.payload, rsp_tdata[stbs_pkg::SLOT_W +: stbs_pkg::PAY_W]);
                  fail_count++;
               end
            end
         end
         // One long back-pressure stretch, otherwise random stalls.
         if (hold_armed && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         cycle_count <= cycle_count + 1;
      end
   end

   task automatic push_write(input int slot, input int key,
                             input logic [stbs_pkg::PAY_W-1:0] pay);
      stbs_pkg::stbs_cmd_type c;
      c.op = stbs_pkg::OP_WRITE;
      c.slot = stbs_pkg::SLOT_W'(slot);
      c.key = key;
      c.payload = pay;
      gen_keys[slot] = key;
      req_backlog.push_back(c);
      phase_queued++;
   endtask

   task automatic push_search(input int key);
      stbs_pkg::stbs_cmd_type c;
      c.op = stbs_pkg::OP_SEARCH;
      c.slot = stbs_pkg::SLOT_W'($urandom_range(DEPTH - 1));
      c.key = key;
      c.payload = {16'($urandom()), $urandom()};
      req_backlog.push_back(c);
      phase_queued++;
   endtask

   function automatic logic [stbs_pkg::PAY_W-1:0] rand_payload();
      return {16'($urandom()), $urandom()};
   endfunction

   // Load slots 0 .. n-1 with ascending keys, written in shuffled slot order.
   task automatic load_sorted_table(input int n);
      int keys [DEPTH];
      int order [DEPTH];
      int base;
      int style;
      int tmp;
      int j;
      style = $urandom_range(3);
      base = $urandom();
      if (style == 2) begin
         base = KEY_MIN;
      end else if (style == 3) begin
         base = KEY_MAX - 60;
      end
      for (int i = 0; i < n; i++) begin
         keys[i] = (style == 0) ? int'($urandom()) : base + int'($urandom_range(60));
         order[i] = i;
      end
      for (int i = 0; i < n; i++) begin
         for (int k = 0; k + 1 < n - i; k++) begin
            if (keys[k] > keys[k + 1]) begin
               tmp = keys[k];
               keys[k] = keys[k + 1];
               keys[k + 1] = tmp;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         j = $urandom_range(n - 1);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < n; i++) begin
         push_write(order[i], keys[order[i]], rand_payload());
      end
   endtask

   // Mostly keys that are in the table, else near misses, else extreme or random keys.
   task automatic push_probe_searches(input int n, input int count);
      int r;
      int k;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         k = gen_keys[$urandom_range((n > 0 ? n : DEPTH) - 1)];
         if (r < 60) begin
            push_search(k);
         end else if (r < 85) begin
            push_search($urandom_range(1) ? k + 1 : k - 1);
         end else begin
            case ($urandom_range(3))
               0: push_search(KEY_MIN);
               1: push_search(KEY_MAX);
               2: push_search(0);
               default: push_search(int'($urandom()));
            endcase
         end
      end
   endtask

   // Wait until nothing is queued or outstanding, plus a margin for a trailing write.
   task automatic wait_idle();
      while (req_backlog.size() > 0 || req_tvalid || lookup_results.size() > 0) begin
         @(negedge clock);
      end
      repeat (10) @(negedge clock);
   endtask

   task automatic write_used(input int v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= stbs_pkg::USED_W'(v);
      @(posedge clock);
      csr_we <= 1'b0;
      used_cfg = stbs_pkg::USED_W'(v);
      settings_used++;
      @(negedge clock);
   endtask

   initial begin
      int used_plan [12];
      int n_eff;
      int r;
      used_plan = '{1, 8, 0, 15, 3, 5, 2, 9, 7, 4, 6, 8};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: extreme keys and payloads in every slot, then hits and misses.
      push_write(0, KEY_MIN, '0);
      push_write(1, -1000, '1);
      push_write(2, -1, 48'h5555_5555_5555);
      push_write(3, 0, 48'haaaa_aaaa_aaaa);
      push_write(4, 1, 48'h0000_0000_0001);
      push_write(5, 1000, 48'h8000_0000_0000);
      push_write(6, KEY_MAX - 1, rand_payload());
      push_write(7, KEY_MAX, rand_payload());
      push_search(KEY_MIN);
      push_search(KEY_MAX);
      push_search(0);
      push_search(-1);
      push_search(1000);
      push_search(-500);
      push_search(2);
      wait_idle();

      // Random phases, each with a table size from used_plan and one of three idle patterns.
      for (int p = 0; p < 12; p++) begin
         write_used(used_plan[p]);
         if (p < 4) begin
            send_idle_pct = 29;
            recv_idle_pct = 57;
         end else if (p < 8) begin
            send_idle_pct = 57;
            recv_idle_pct = 29;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 2) begin
            hold_armed = 1'b1;
         end
         n_eff = (used_plan[p] > DEPTH) ? DEPTH : used_plan[p];
         phase_queued = 0;
         while (phase_queued < PHASE_BEATS) begin
            r = $urandom_range(99);
            if (r < 75) begin
               // Well-formed: a fresh sorted table, then a burst of searches.
               load_sorted_table(n_eff > 0 ? n_eff : DEPTH);
               push_probe_searches(n_eff, $urandom_range(3, 8));
            end else if (r < 90) begin
               // Noise: stray writes that may leave the table unsorted.
               repeat ($urandom_range(1, 3)) begin
                  push_write($urandom_range(DEPTH - 1), int'($urandom()), rand_payload());
               end
               push_probe_searches(n_eff, $urandom_range(1, 4));
            end else begin
               // Broken sequence: only part of a sorted table gets rewritten.
               load_sorted_table($urandom_range(1, DEPTH));
               push_probe_searches(n_eff, $urandom_range(1, 4));
            end
         end
         wait_idle();
      end

      $display("Covered %0d write beats and %0d search beats (%0d hits) over %0d table sizes.",
               write_beats, search_beats, hit_beats, settings_used);
      $display("Idle patterns: sender-heavy, receiver-heavy, none; one %0d-cycle output stall.",
               LONG_HOLD);
      if (fail_count == 0 && lookup_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/stbs_pkg.sv
rtl/stbs_engine.sv
rtl/sorted_table_binary_search.sv
verif/testbench.sv
